FILE: src/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int SLOT_BITS = 4;
    localparam int PRIO_BITS = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_REPORT
    } state_t;

    // Control part of the candidate that walks the cell chain.
    typedef struct packed {
        logic go;          // token present this cycle
        logic found;       // a ready task has been picked so far
        logic pend_other;  // some unfinished task other than the pick exists
        logic last_unit;   // the pick has one unit left
    } scan_ctl_t;

endpackage

FILE: src/pps_cell.sv
// One task slot: holds the task and merges it into the passing candidate.
module pps_cell #(
    parameter int INDEX     = 0,
    parameter int IW        = 4,
    parameter int TW        = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [TW-1:0]                 now,
    // load command
    input  logic                          ld_en,
    input  logic [pps_pkg::SLOT_BITS-1:0] ld_slot,
    input  logic [TW-1:0]                 ld_arrival,
    input  logic [TW-1:0]                 ld_burst,
    input  logic [pps_pkg::PRIO_BITS-1:0] ld_prio,
    // run-one-unit command
    input  logic                          upd_en,
    input  logic [IW-1:0]                 upd_idx,
    // candidate in from the lower slot
    input  pps_pkg::scan_ctl_t            in_ctl,
    input  logic [pps_pkg::PRIO_BITS-1:0] in_prio,
    input  logic [TW-1:0]                 in_arrival,
    input  logic [TW-1:0]                 in_burst,
    input  logic [TW-1:0]                 in_first,
    input  logic [IW-1:0]                 in_idx,
    // candidate out to the next slot
    output pps_pkg::scan_ctl_t            out_ctl,
    output logic [pps_pkg::PRIO_BITS-1:0] out_prio,
    output logic [TW-1:0]                 out_arrival,
    output logic [TW-1:0]                 out_burst,
    output logic [TW-1:0]                 out_first,
    output logic [IW-1:0]                 out_idx
);

    logic                          loaded_reg;
    logic                          started_reg;
    logic                          done_reg;
    logic [TW-1:0]                 arrival_reg;
    logic [TW-1:0]                 burst_reg;
    logic [TW-1:0]                 left_reg;
    logic [TW-1:0]                 first_reg;
    logic [pps_pkg::PRIO_BITS-1:0] prio_reg;

    pps_pkg::scan_ctl_t            ctl_reg;
    pps_pkg::scan_ctl_t            ctl_next;
    logic [pps_pkg::PRIO_BITS-1:0] cprio_reg;
    logic [TW-1:0]                 carrival_reg;
    logic [TW-1:0]                 cburst_reg;
    logic [TW-1:0]                 cfirst_reg;
    logic [IW-1:0]                 cidx_reg;

    logic ld_hit;
    logic upd_hit;
    logic pending;
    logic ready;
    logic win;

    assign ld_hit  = ld_en && ({{(32-pps_pkg::SLOT_BITS){1'b0}}, ld_slot} == 32'(INDEX));
    assign upd_hit = upd_en && (upd_idx == IW'(INDEX));
    assign pending = loaded_reg && !done_reg;
    assign ready   = pending && (left_reg != '0) && (arrival_reg <= now);
    // incoming candidate comes from a lower slot, so only a strict win replaces it
    assign win     = ready && (!in_ctl.found || (prio_reg < in_prio) ||
                     ((prio_reg == in_prio) && (arrival_reg < in_arrival)));

    always_comb
    begin
        ctl_next    = in_ctl;
        if (win)
        begin
            ctl_next.found      = 1'b1;
            ctl_next.pend_other = in_ctl.pend_other || in_ctl.found;
            ctl_next.last_unit  = (left_reg == TW'(1));
        end
        else
        begin
            ctl_next.pend_other = in_ctl.pend_other || pending;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg  <= 1'b0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (ld_hit)
        begin
            loaded_reg  <= 1'b1;
            started_reg <= 1'b0;
            done_reg    <= (ld_burst == '0);
        end
        else if (upd_hit)
        begin
            started_reg <= 1'b1;
            if (left_reg == TW'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_hit)
        begin
            arrival_reg <= ld_arrival;
            burst_reg   <= ld_burst;
            left_reg    <= ld_burst;
            prio_reg    <= ld_prio;
        end
        else if (upd_hit)
        begin
            left_reg <= left_reg - TW'(1);
            if (!started_reg)
            begin
                first_reg <= now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (in_ctl.go)
        begin
            ctl_reg <= ctl_next;
        end
        else
        begin
            ctl_reg.go <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.go)
        begin
            if (win)
            begin
                cprio_reg    <= prio_reg;
                carrival_reg <= arrival_reg;
                cburst_reg   <= burst_reg;
                cfirst_reg   <= started_reg ? first_reg : now;
                cidx_reg     <= IW'(INDEX);
            end
            else
            begin
                cprio_reg    <= in_prio;
                carrival_reg <= in_arrival;
                cburst_reg   <= in_burst;
                cfirst_reg   <= in_first;
                cidx_reg     <= in_idx;
            end
        end
    end

    assign out_ctl     = ctl_reg;
    assign out_prio    = cprio_reg;
    assign out_arrival = carrival_reg;
    assign out_burst   = cburst_reg;
    assign out_first   = cfirst_reg;
    assign out_idx     = cidx_reg;

endmodule

FILE: src/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler: task cell chain, tick sequencer and result registers.
// A load is taken while idle and busy stays low after it.
// A tick holds busy while the candidate walks the cell chain one slot per cycle,
// then the apply state runs the pick and the report state registers the times.
// result_valid pulses for one cycle as busy drops; a tick is taken only while busy is low.
// Reset clears the clock and all loaded/started/done flags; the table is empty.
module preemptive_priority_scheduler_top #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [pps_pkg::SLOT_BITS-1:0] slot,
    input  logic [TIME_BITS-1:0]          arrival,
    input  logic [TIME_BITS-1:0]          burst,
    input  logic [pps_pkg::PRIO_BITS-1:0] prio,
    output logic                          result_valid,
    output logic [pps_pkg::SLOT_BITS-1:0] running_slot,
    output logic                          cpu_idle,
    output logic                          task_finished,
    output logic [TIME_BITS-1:0]          first_run_time,
    output logic [TIME_BITS-1:0]          finish_time,
    output logic [TIME_BITS-1:0]          turnaround,
    output logic [TIME_BITS-1:0]          wait_time,
    output logic                          all_done,
    output logic [TIME_BITS-1:0]          now_time
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TW = TIME_BITS;

    pps_pkg::state_t state_reg;
    pps_pkg::state_t state_next;

    logic [TW-1:0] now_reg;
    logic [TW-1:0] now_inc;

    logic accept;
    logic inject;
    logic ld_en;
    logic upd_en;

    pps_pkg::scan_ctl_t            ch_ctl     [MAX_TASKS+1];
    logic [pps_pkg::PRIO_BITS-1:0] ch_prio    [MAX_TASKS+1];
    logic [TW-1:0]                 ch_arrival [MAX_TASKS+1];
    logic [TW-1:0]                 ch_burst   [MAX_TASKS+1];
    logic [TW-1:0]                 ch_first   [MAX_TASKS+1];
    logic [IW-1:0]                 ch_idx     [MAX_TASKS+1];

    pps_pkg::scan_ctl_t best;
    logic               fin_now;

    // registers between the run cycle and the report cycle
    logic                          r_found_reg;
    logic                          r_fin_reg;
    logic                          r_all_reg;
    logic [pps_pkg::SLOT_BITS-1:0] r_slot_reg;
    logic [TW-1:0]                 r_first_reg;
    logic [TW-1:0]                 r_finish_reg;
    logic [TW-1:0]                 r_tat_reg;
    logic [TW-1:0]                 r_burst_reg;
    logic [TW-1:0]                 wt_calc;

    logic                          valid_reg;
    logic [pps_pkg::SLOT_BITS-1:0] o_slot_reg;
    logic                          o_idle_reg;
    logic                          o_fin_reg;
    logic [TW-1:0]                 o_first_reg;
    logic [TW-1:0]                 o_finish_reg;
    logic [TW-1:0]                 o_tat_reg;
    logic [TW-1:0]                 o_wt_reg;
    logic                          o_all_reg;
    logic [TW-1:0]                 o_now_reg;

    assign accept  = start && !busy;
    assign now_inc = (now_reg != '1) ? (now_reg + TW'(1)) : now_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                if (start && (opcode == pps_pkg::OP_TICK))
                begin
                    state_next = pps_pkg::ST_SCAN;
                end
            end
            pps_pkg::ST_SCAN:
            begin
                if (ch_ctl[MAX_TASKS].go)
                begin
                    state_next = pps_pkg::ST_APPLY;
                end
            end
            pps_pkg::ST_APPLY:  state_next = pps_pkg::ST_REPORT;
            pps_pkg::ST_REPORT: state_next = pps_pkg::ST_IDLE;
            default:            state_next = pps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = 1'b1;
        inject = 1'b0;
        ld_en  = 1'b0;
        upd_en = 1'b0;
        unique case (state_reg)
            pps_pkg::ST_IDLE:
            begin
                busy   = 1'b0;
                inject = start && (opcode == pps_pkg::OP_TICK);
                ld_en  = start && (opcode == pps_pkg::OP_LOAD);
            end
            pps_pkg::ST_APPLY:
            begin
                upd_en = best.found;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pps_pkg::ST_IDLE;
            now_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pps_pkg::ST_APPLY)
            begin
                now_reg <= now_inc;
            end
        end
    end

    // head of the chain: empty candidate
    assign ch_ctl[0]     = '{go: inject, found: 1'b0, pend_other: 1'b0, last_unit: 1'b0};
    assign ch_prio[0]    = '0;
    assign ch_arrival[0] = '0;
    assign ch_burst[0]   = '0;
    assign ch_first[0]   = '0;
    assign ch_idx[0]     = '0;

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        pps_cell #(
            .INDEX (i),
            .IW    (IW),
            .TW    (TW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .now         (now_reg),
            .ld_en       (ld_en),
            .ld_slot     (slot),
            .ld_arrival  (arrival),
            .ld_burst    (burst),
            .ld_prio     (prio),
            .upd_en      (upd_en),
            .upd_idx     (ch_idx[MAX_TASKS]),
            .in_ctl      (ch_ctl[i]),
            .in_prio     (ch_prio[i]),
            .in_arrival  (ch_arrival[i]),
            .in_burst    (ch_burst[i]),
            .in_first    (ch_first[i]),
            .in_idx      (ch_idx[i]),
            .out_ctl     (ch_ctl[i+1]),
            .out_prio    (ch_prio[i+1]),
            .out_arrival (ch_arrival[i+1]),
            .out_burst   (ch_burst[i+1]),
            .out_first   (ch_first[i+1]),
            .out_idx     (ch_idx[i+1])
        );
    end

    assign best    = ch_ctl[MAX_TASKS];
    assign fin_now = best.found && best.last_unit;

    always_ff @(posedge clk)
    begin
        if (state_reg == pps_pkg::ST_APPLY)
        begin
            r_found_reg  <= best.found;
            r_fin_reg    <= fin_now;
            r_all_reg    <= !best.pend_other && !(best.found && !best.last_unit);
            r_slot_reg   <= best.found ? pps_pkg::SLOT_BITS'(ch_idx[MAX_TASKS]) : '0;
            r_first_reg  <= fin_now ? ch_first[MAX_TASKS] : '0;
            r_finish_reg <= fin_now ? now_inc : '0;
            r_tat_reg    <= fin_now ? (now_inc - ch_arrival[MAX_TASKS]) : '0;
            r_burst_reg  <= fin_now ? ch_burst[MAX_TASKS] : '0;
        end
    end

    // clamps at zero when clock saturation shortened the turnaround
    assign wt_calc = (r_tat_reg >= r_burst_reg) ? (r_tat_reg - r_burst_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= (state_reg == pps_pkg::ST_REPORT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pps_pkg::ST_REPORT)
        begin
            o_slot_reg   <= r_slot_reg;
            o_idle_reg   <= !r_found_reg;
            o_fin_reg    <= r_fin_reg;
            o_first_reg  <= r_first_reg;
            o_finish_reg <= r_finish_reg;
            o_tat_reg    <= r_tat_reg;
            o_wt_reg     <= wt_calc;
            o_all_reg    <= r_all_reg;
            o_now_reg    <= now_reg;
        end
    end

    assign result_valid   = valid_reg;
    assign running_slot   = o_slot_reg;
    assign cpu_idle       = o_idle_reg;
    assign task_finished  = o_fin_reg;
    assign first_run_time = o_first_reg;
    assign finish_time    = o_finish_reg;
    assign turnaround     = o_tat_reg;
    assign wait_time      = o_wt_reg;
    assign all_done       = o_all_reg;
    assign now_time       = o_now_reg;

endmodule

FILE: src/pps_chk.sv
// Port-level checks for the preemptive priority scheduler, bound to the top level.
module pps_chk #(
    parameter int TIME_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          opcode,
    input logic                          result_valid,
    input logic                          cpu_idle,
    input logic                          task_finished,
    input logic [TIME_BITS-1:0]          turnaround,
    input logic [TIME_BITS-1:0]          wait_time
);

    // a result only shows once the tick is over
    a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // a load transfer never produces a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == pps_pkg::OP_LOAD)) |=> !result_valid)
        else $error("result after a load");

    // a tick transfer occupies the block
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == pps_pkg::OP_TICK)) |=> busy)
        else $error("tick did not raise busy");

    a_idle_no_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && cpu_idle) |-> !task_finished)
        else $error("finish reported on an idle tick");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && task_finished) |-> (wait_time <= turnaround))
        else $error("wait exceeds turnaround");

endmodule

bind preemptive_priority_scheduler_top pps_chk #(
    .TIME_BITS (TIME_BITS)
) u_pps_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .result_valid  (result_valid),
    .cpu_idle      (cpu_idle),
    .task_finished (task_finished),
    .turnaround    (turnaround),
    .wait_time     (wait_time)
);

FILE: tb/pps_checker.sv
// Scoreboard for the priority scheduler: tracks the task table, predicts each tick, compares.
`timescale 1ns / 1ps
module pps_checker #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          opcode,
    input  logic [pps_pkg::SLOT_BITS-1:0] slot,
    input  logic [TIME_BITS-1:0]          arrival,
    input  logic [TIME_BITS-1:0]          burst,
    input  logic [pps_pkg::PRIO_BITS-1:0] prio,
    input  logic                          result_valid,
    input  logic [pps_pkg::SLOT_BITS-1:0] running_slot,
    input  logic                          cpu_idle,
    input  logic                          task_finished,
    input  logic [TIME_BITS-1:0]          first_run_time,
    input  logic [TIME_BITS-1:0]          finish_time,
    input  logic [TIME_BITS-1:0]          turnaround,
    input  logic [TIME_BITS-1:0]          wait_time,
    input  logic                          all_done,
    input  logic [TIME_BITS-1:0]          now_time,
    output int                            fail_count,
    output int                            outstanding
);

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        logic [pps_pkg::SLOT_BITS-1:0] run_slot;
        logic                          idle;
        logic                          finished;
        logic [TIME_BITS-1:0]          first;
        logic [TIME_BITS-1:0]          fin;
        logic [TIME_BITS-1:0]          tat;
        logic [TIME_BITS-1:0]          wt;
        logic                          every_done;
        logic [TIME_BITS-1:0]          now;
    } tick_report_t;

    logic [TIME_BITS-1:0]          sched_clock;
    logic [TIME_BITS-1:0]          t_arrival [MAX_TASKS];
    logic [TIME_BITS-1:0]          t_burst   [MAX_TASKS];
    logic [TIME_BITS-1:0]          t_left    [MAX_TASKS];
    logic [pps_pkg::PRIO_BITS-1:0] t_prio    [MAX_TASKS];
    logic [TIME_BITS-1:0]          t_first   [MAX_TASKS];
    logic                          t_loaded  [MAX_TASKS];
    logic                          t_started [MAX_TASKS];
    logic                          t_done    [MAX_TASKS];

    tick_report_t expected_ticks[$];

    // One scheduling step: pick the most urgent ready task, run it one unit, advance time.
    function automatic tick_report_t schedule_tick();
        int           pick;
        tick_report_t r;
        pick = -1;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (t_loaded[i] && !t_done[i] && t_left[i] != 0 && t_arrival[i] <= sched_clock)
            begin
                if (pick < 0 || t_prio[i] < t_prio[pick] ||
                    (t_prio[i] == t_prio[pick] && t_arrival[i] < t_arrival[pick]))
                    pick = i;
            end
        end
        r = '0;
        if (pick >= 0)
        begin
            if (!t_started[pick])
            begin
                t_first[pick]   = sched_clock;
                t_started[pick] = 1'b1;
            end
            t_left[pick] = t_left[pick] - 1'b1;
        end
        if (sched_clock != TIME_MAX)
            sched_clock = sched_clock + 1'b1;
        r.idle = (pick < 0);
        if (pick >= 0)
        begin
            r.run_slot = pps_pkg::SLOT_BITS'(pick);
            if (t_left[pick] == 0)
            begin
                t_done[pick] = 1'b1;
                r.finished   = 1'b1;
                r.first      = t_first[pick];
                r.fin        = sched_clock;
                r.tat        = sched_clock - t_arrival[pick];
                // saturated time can make turnaround shorter than the burst
                r.wt         = (r.tat >= t_burst[pick]) ? r.tat - t_burst[pick] : '0;
            end
        end
        r.every_done = 1'b1;
        for (int i = 0; i < MAX_TASKS; i++)
            if (t_loaded[i] && !t_done[i])
                r.every_done = 1'b0;
        r.now = sched_clock;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch on %s: expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_report_t want;
        if (!rst_n)
        begin
            fail_count  = 0;
            sched_clock = '0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                t_loaded[i]  = 1'b0;
                t_started[i] = 1'b0;
                t_done[i]    = 1'b0;
                t_arrival[i] = '0;
                t_burst[i]   = '0;
                t_left[i]    = '0;
                t_prio[i]    = '0;
                t_first[i]   = '0;
            end
            expected_ticks.delete();
        end
        else
        begin
            // results first: a tick taken on this edge cannot report on it
            if (result_valid === 1'b1)
            begin
                if (expected_ticks.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t unexpected result, slot %0d idle %0b now %0d",
                                 $time, running_slot, cpu_idle, now_time);
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("running_slot", 32'(want.run_slot), 32'(running_slot));
                    check_field("cpu_idle", 32'(want.idle), 32'(cpu_idle));
                    check_field("task_finished", 32'(want.finished), 32'(task_finished));
                    check_field("first_run_time", 32'(want.first), 32'(first_run_time));
                    check_field("finish_time", 32'(want.fin), 32'(finish_time));
                    check_field("turnaround", 32'(want.tat), 32'(turnaround));
                    check_field("wait_time", 32'(want.wt), 32'(wait_time));
                    check_field("all_done", 32'(want.every_done), 32'(all_done));
                    check_field("now_time", 32'(want.now), 32'(now_time));
                end
            end
            if (start && !busy)
            begin
                if (opcode == pps_pkg::OP_LOAD)
                begin
                    if (slot < MAX_TASKS)
                    begin
                        t_arrival[slot] = arrival;
                        t_burst[slot]   = burst;
                        t_left[slot]    = burst;
                        t_prio[slot]    = prio;
                        t_loaded[slot]  = 1'b1;
                        t_started[slot] = 1'b0;
                        t_done[slot]    = (burst == 0);
                    end
                end
                else
                begin
                    expected_ticks.push_back(schedule_tick());
                end
            end
        end
        outstanding = expected_ticks.size();
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the priority scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam int     MAX_TASKS    = 16;
    localparam int     TIME_BITS    = 16;
    localparam int     PHASE_ITEMS  = 467;
    localparam longint CYCLE_LIMIT  = 4_000_000;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          start    = 1'b0;
    logic                          opcode   = pps_pkg::OP_LOAD;
    logic [pps_pkg::SLOT_BITS-1:0] slot     = '0;
    logic [TIME_BITS-1:0]          arrival  = '0;
    logic [TIME_BITS-1:0]          burst    = '0;
    logic [pps_pkg::PRIO_BITS-1:0] prio     = '0;

    logic                          busy;
    logic                          result_valid;
    logic [pps_pkg::SLOT_BITS-1:0] running_slot;
    logic                          cpu_idle;
    logic                          task_finished;
    logic [TIME_BITS-1:0]          first_run_time;
    logic [TIME_BITS-1:0]          finish_time;
    logic [TIME_BITS-1:0]          turnaround;
    logic [TIME_BITS-1:0]          wait_time;
    logic                          all_done;
    logic [TIME_BITS-1:0]          now_time;

    int     fail_count;
    int     outstanding;
    int     idle_pct   = 0;
    int     items_sent = 0;
    int     ticks_sent = 0;
    longint cycles     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    preemptive_priority_scheduler_top #(
        .MAX_TASKS(MAX_TASKS),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .slot(slot), .arrival(arrival), .burst(burst), .prio(prio),
        .result_valid(result_valid), .running_slot(running_slot), .cpu_idle(cpu_idle),
        .task_finished(task_finished), .first_run_time(first_run_time),
        .finish_time(finish_time), .turnaround(turnaround), .wait_time(wait_time),
        .all_done(all_done), .now_time(now_time)
    );

    pps_checker #(
        .MAX_TASKS(MAX_TASKS),
        .TIME_BITS(TIME_BITS)
    ) checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .slot(slot), .arrival(arrival), .burst(burst), .prio(prio),
        .result_valid(result_valid), .running_slot(running_slot), .cpu_idle(cpu_idle),
        .task_finished(task_finished), .first_run_time(first_run_time),
        .finish_time(finish_time), .turnaround(turnaround), .wait_time(wait_time),
        .all_done(all_done), .now_time(now_time),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one command, idling at random first; returns once the transfer is taken.
    task automatic send_item(input logic op, input logic [pps_pkg::SLOT_BITS-1:0] s,
                             input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b,
                             input logic [pps_pkg::PRIO_BITS-1:0] p);
        bit presented;
        presented = 1'b0;
        while (!presented)
        begin
            @(negedge clk);
            if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
            end
            else
            begin
                start     <= 1'b1;
                opcode    <= op;
                slot      <= s;
                arrival   <= a;
                burst     <= b;
                prio      <= p;
                presented = 1'b1;
            end
        end
        do @(posedge clk); while (busy);
        items_sent++;
        if (op == pps_pkg::OP_TICK)
            ticks_sent++;
    endtask

    task automatic send_load(input logic [pps_pkg::SLOT_BITS-1:0] s,
                             input logic [TIME_BITS-1:0] a,
                             input logic [TIME_BITS-1:0] b,
                             input logic [pps_pkg::PRIO_BITS-1:0] p);
        send_item(pps_pkg::OP_LOAD, s, a, b, p);
    endtask

    // load fields are don't-care on a tick; keep them toggling
    task automatic send_tick();
        send_item(pps_pkg::OP_TICK, pps_pkg::SLOT_BITS'($urandom), TIME_BITS'($urandom),
                  TIME_BITS'($urandom), pps_pkg::PRIO_BITS'($urandom));
    endtask

    // scheduler time a little ahead of now, clipped at the top of the range
    function automatic logic [TIME_BITS-1:0] time_ahead(input int ahead);
        longint t;
        t = longint'(ticks_sent) + ahead;
        return (t > 65535) ? 16'hFFFF : TIME_BITS'(t);
    endfunction

    task automatic run_batch();
        int                            n;
        logic [TIME_BITS-1:0]          b;
        logic [pps_pkg::PRIO_BITS-1:0] p;
        if ($urandom_range(99) < 75)
        begin
            // a group of tasks near the current time, then ticks with late arrivals mixed in
            n = $urandom_range(1, 5);
            for (int k = 0; k < n + $urandom_range(4, 30); k++)
            begin
                if (k < n || $urandom_range(99) < 8)
                begin
                    b = ($urandom_range(99) < 10) ? TIME_BITS'($urandom_range(1, 200))
                                                  : TIME_BITS'($urandom_range(1, 8));
                    p = ($urandom_range(99) < 70) ? pps_pkg::PRIO_BITS'($urandom_range(0, 3))
                                                  : pps_pkg::PRIO_BITS'($urandom);
                    send_load(pps_pkg::SLOT_BITS'($urandom),
                              time_ahead($urandom_range(0, 15)), b, p);
                end
                else
                begin
                    send_tick();
                end
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(1))
                    send_tick();
                else
                    send_load(pps_pkg::SLOT_BITS'($urandom), TIME_BITS'($urandom),
                              ($urandom_range(99) < 10) ? '0 : TIME_BITS'($urandom),
                              pps_pkg::PRIO_BITS'($urandom));
            end
        end
    endtask

    initial
    begin
        int phase_base;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, zero burst, ties, preemption, reload, field extremes
        send_tick();
        send_load(4'd15, 16'd0, 16'd0, 8'd255);
        send_tick();
        send_load(4'd0, 16'd0, 16'd3, 8'd5);
        send_load(4'd3, 16'd0, 16'd2, 8'd5);
        send_load(4'd5, 16'd2, 16'd2, 8'd5);
        send_load(4'd7, 16'd1, 16'd1, 8'd0);
        repeat (4) send_tick();
        send_load(4'd0, 16'd3, 16'd2, 8'd5);
        repeat (6) send_tick();
        send_load(4'd14, 16'd0, 16'hFFFF, 8'd255);
        send_load(4'd1, 16'hFFFF, 16'd1, 8'd0);
        repeat (3) send_tick();

        idle_pct = 10;
        phase_base = items_sent;
        while (items_sent - phase_base < PHASE_ITEMS)
            run_batch();
        idle_pct = 74;
        phase_base = items_sent;
        while (items_sent - phase_base < PHASE_ITEMS)
            run_batch();
        idle_pct = 0;
        phase_base = items_sent;
        while (items_sent - phase_base < PHASE_ITEMS)
            run_batch();

        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
